### sv/fixed_weight_index_sampler_unit_assert.svh
// assertion macros of the sampler checker
`ifndef FIXED_WEIGHT_INDEX_SAMPLER_UNIT_ASSERT_SVH
`define FIXED_WEIGHT_INDEX_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FWIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fwis assertion failed");

// next-cycle implication, disabled in reset
`define FWIS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fwis assertion failed");

`endif

### sv/fwis_pkg.sv
// shared constants and types of the fixed-weight index sampler
`timescale 1ns / 1ps

package fwis_pkg;

  // field widths
  localparam int WORD_W    = 64;
  localparam int STEP_W    = 6;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int POS_W     = 12;
  localparam int CNT_W     = 13;

  // bitmap memory row geometry
  localparam int ROW_W     = 64;
  localparam int ROW_SEL_W = 6;

  // default largest vector length
  localparam int DEF_MAX_LENGTH = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WEIGHT = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] RST_VECTOR_LENGTH = 13'd4096;
  localparam logic [CFG_W-1:0] RST_TARGET_WEIGHT = 13'd16;

  // item op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_WORD  = 1'b1;

  // requests from the sequencer to the bitmap
  typedef struct packed {
    logic clear;
    logic lookup;
    logic set_ok;
  } map_req_t;

  // status from the bitmap to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic fresh;
  } map_rsp_t;

endpackage

### sv/fwis_if.sv
// item channels of the fixed-weight index sampler
`timescale 1ns / 1ps

interface fwis_in_if import fwis_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output op, output random_word, input ready);
  modport sink   (input valid, input op, input random_word, output ready);
endinterface

interface fwis_out_if import fwis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             newly_chosen;
  logic [CNT_W-1:0] chosen_count;
  logic             done_res;

  modport source (output valid, output position, output newly_chosen,
                  output chosen_count, output done_res, input ready);
  modport sink   (input valid, input position, input newly_chosen,
                  input chosen_count, input done_res, output ready);
endinterface

### sv/fwis_div.sv
// bit-serial remainder unit: 64-bit word modulo the vector length
`timescale 1ns / 1ps

module fwis_div import fwis_pkg::*; #(
  parameter int CW = CFG_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [CW-1:0]     divisor_i,
  output logic              done_o,
  output logic [CW-1:0]     rem_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [WORD_W-1:0] dvd_q;
  logic [CW-1:0]     dvs_q;
  logic [CW-1:0]     rem_q;
  logic [CW:0]       trial;
  logic [CW-1:0]     rem_d;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[WORD_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      trial = trial - {1'b0, dvs_q};
    end
    rem_d = trial[CW-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### sv/fwis_map.sv
// chosen-position bitmap: row memory with clearing pass and read-modify-write
`timescale 1ns / 1ps

module fwis_map import fwis_pkg::*; #(
  parameter int MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int CW         = CFG_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  map_req_t      req_i,
  input  logic [CW-1:0] pos_i,
  output map_rsp_t      rsp_o
);

  localparam int ROWS = (MAX_LENGTH + ROW_W - 1) / ROW_W;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {
    MS_CLEAR,
    MS_IDLE,
    MS_CHECK
  } map_state_e;

  map_state_e           state_q;
  logic [RAW-1:0]       clr_row_q;
  logic [RAW-1:0]       row_q;
  logic [ROW_SEL_W-1:0] bit_q;
  logic                 set_ok_q;
  logic                 done_q;
  logic                 fresh_q;

  logic [ROW_W-1:0]     row_mem [ROWS];
  logic [ROW_W-1:0]     rdata_q;
  logic [RAW-1:0]       raddr;
  logic                 we;
  logic [RAW-1:0]       waddr;
  logic [ROW_W-1:0]     wdata;
  logic                 fresh;

  // lookup address and update of the addressed row
  always_comb begin
    raddr = pos_i[ROW_SEL_W +: RAW];
    fresh = set_ok_q && !rdata_q[bit_q];
    we    = 1'b0;
    waddr = row_q;
    wdata = rdata_q | (ROW_W'(1) << bit_q);
    if (state_q == MS_CLEAR) begin
      we    = 1'b1;
      waddr = clr_row_q;
      wdata = '0;
    end else if (state_q == MS_CHECK) begin
      we    = fresh;
    end
  end

  // row memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      row_mem[waddr] <= wdata;
    end
    rdata_q <= row_mem[raddr];
  end

  // sequencer of clearing pass and lookups
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= MS_CLEAR;
      clr_row_q <= '0;
      row_q     <= '0;
      bit_q     <= '0;
      set_ok_q  <= 1'b0;
      done_q    <= 1'b0;
      fresh_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        MS_CLEAR: begin
          clr_row_q <= clr_row_q + RAW'(1);
          if (clr_row_q == RAW'(ROWS - 1)) begin
            clr_row_q <= '0;
            done_q    <= 1'b1;
            fresh_q   <= 1'b0;
            state_q   <= MS_IDLE;
          end
        end
        MS_IDLE: begin
          if (req_i.clear) begin
            state_q <= MS_CLEAR;
          end else if (req_i.lookup) begin
            row_q    <= raddr;
            bit_q    <= pos_i[ROW_SEL_W-1:0];
            set_ok_q <= req_i.set_ok;
            state_q  <= MS_CHECK;
          end
        end
        MS_CHECK: begin
          done_q  <= 1'b1;
          fresh_q <= fresh;
          state_q <= MS_IDLE;
        end
        default: begin
          state_q <= MS_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.busy  = (state_q != MS_IDLE);
  assign rsp_o.done  = done_q;
  assign rsp_o.fresh = fresh_q;

endmodule

### sv/fixed_weight_index_sampler_unit.sv
// Fixed-weight index sampler: picks distinct positions below the vector length.
// Channels: in_i carries items (op, random_word), out_o carries one result item
// (position, newly_chosen, chosen_count, done_res) per input item, both
// valid/ready. Registers vector_length and target_weight are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user writes them only while no item
// is in flight, and the block itself does not enforce this.
// A word item passes 64 steps of the bit-serial remainder unit, the hand-over
// of the remainder with the read of the bitmap row, a check and write-back, a
// count update, and the load of the output register, which waits while the
// receiver stalls a held result. A start item clears the bitmap one 64-bit
// row a cycle. One item is worked on at a time; the next is taken once the
// result sits in the output register, so a stalled receiver holds the result
// while the block takes and works on the next item.
// Reset: registers return to length 4096 and weight 16, the count goes to zero,
// and a clearing pass wipes the bitmap; in_i.ready stays low until it ends.
`timescale 1ns / 1ps

module fixed_weight_index_sampler_unit import fwis_pkg::*; #(
  parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fwis_in_if.sink              in_i,
  fwis_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int NW = $clog2(MAX_LENGTH + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] len_q;
  logic [CFG_W-1:0] tgt_q;
  logic [CNT_W-1:0] cnt_q;
  logic [POS_W-1:0] res_pos_q;
  logic             res_fresh_q;
  logic             out_valid_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_fresh_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_done_q;

  logic [CW-1:0]    len_ext;
  logic [CW-1:0]    tgt_ext;
  logic [CW-1:0]    cnt_ext;
  logic [CW-1:0]    n_eff;
  logic [CW-1:0]    t_eff;
  logic             in_acc;
  logic             div_start;
  logic             div_done;
  logic [CW-1:0]    div_rem;
  map_req_t         map_req;
  map_rsp_t         map_rsp;

  // effective length and target
  always_comb begin
    len_ext = CW'(len_q);
    tgt_ext = CW'(tgt_q);
    cnt_ext = CW'(cnt_q);
    if (len_ext == '0) begin
      n_eff = CW'(1);
    end else if (len_ext > CW'(MAX_LENGTH)) begin
      n_eff = CW'(MAX_LENGTH);
    end else begin
      n_eff = len_ext;
    end
    t_eff = (tgt_ext < n_eff) ? tgt_ext : n_eff;
  end

  // handshake and unit requests
  assign in_i.ready     = (state_q == ST_IDLE) && !map_rsp.busy;
  assign in_acc         = in_i.valid && in_i.ready;
  assign div_start      = in_acc && (in_i.op == OP_WORD);
  assign map_req.clear  = in_acc && (in_i.op == OP_START);
  assign map_req.lookup = (state_q == ST_DIV) && div_done;
  assign map_req.set_ok = (cnt_ext < t_eff);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= RST_VECTOR_LENGTH;
      tgt_q <= RST_TARGET_WEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VECTOR_LENGTH: len_q <= cfg_data_i;
        REG_TARGET_WEIGHT: tgt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item sequencer with count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_pos_q   <= '0;
      res_fresh_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_fresh_q <= 1'b0;
      out_cnt_q   <= '0;
      out_done_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.op == OP_START) begin
              cnt_q       <= '0;
              res_pos_q   <= '0;
              res_fresh_q <= 1'b0;
              state_q     <= ST_CLEAR;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_pos_q <= div_rem[POS_W-1:0];
            state_q   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (map_rsp.done) begin
            res_fresh_q <= map_rsp.fresh;
            cnt_q       <= cnt_q + CNT_W'(map_rsp.fresh);
            state_q     <= ST_FINISH;
          end
        end
        ST_CLEAR: begin
          if (map_rsp.done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_pos_q   <= res_pos_q;
            out_fresh_q <= res_fresh_q;
            out_cnt_q   <= cnt_q;
            out_done_q  <= (cnt_ext >= t_eff);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.position     = out_pos_q;
  assign out_o.newly_chosen = out_fresh_q;
  assign out_o.chosen_count = out_cnt_q;
  assign out_o.done_res     = out_done_q;

  // remainder unit
  fwis_div #(
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_i.random_word),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // chosen-position bitmap
  fwis_map #(
    .MAX_LENGTH (MAX_LENGTH),
    .CW         (CW)
  ) u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .pos_i  (div_rem),
    .rsp_o  (map_rsp)
  );

endmodule

### sv/fwis_checker.sv
// port-level checker of the sampler, bound to the top level
`timescale 1ns / 1ps
`include "fixed_weight_index_sampler_unit_assert.svh"

module fwis_checker import fwis_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_newly_chosen_i,
  input logic [CNT_W-1:0] out_chosen_count_i
);

  // a result waiting for the receiver stays offered
  `FWIS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result keeps its count
  `FWIS_ASSERT_NXT(a_cnt_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_chosen_count_i))

  // one item at a time: no acceptance right after an acceptance
  `FWIS_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a newly chosen position always leaves a nonzero count
  `FWIS_ASSERT_IMP(a_fresh_cnt, clk_i, rst_ni, out_valid_i && out_newly_chosen_i, out_chosen_count_i != '0)

endmodule

bind fixed_weight_index_sampler_unit fwis_checker u_fwis_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_newly_chosen_i (out_o.newly_chosen),
  .out_chosen_count_i (out_o.chosen_count)
);

### verif/tb.sv
// self-checking testbench of the fixed-weight index sampler
`timescale 1ns / 1ps

module tb;
  import fwis_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_ITEMS  = 40;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] word;
  } sampler_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             newly_chosen;
    logic [CNT_W-1:0] chosen_count;
    logic             done_res;
  } sampler_res_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fwis_in_if  in_if ();
  fwis_out_if out_if ();

  fixed_weight_index_sampler_unit #(
    .MAX_LENGTH(DEF_MAX_LENGTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor copy of the bitmap, count and registers
  logic [DEF_MAX_LENGTH-1:0] chosen_map;
  logic [CNT_W-1:0]          picked_count;
  logic [CFG_W-1:0]          len_reg;
  logic [CFG_W-1:0]          weight_reg;

  sampler_item_t pending_items_q[$];
  sampler_res_t  expected_res_q[$];

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_fresh;
  int unsigned n_done;
  int unsigned n_settings;
  int unsigned n_fail;
  int unsigned stall_cycles;
  int          send_pct;
  int          recv_pct;
  logic        in_fire;

  // clock
  always #5 clk_i = ~clk_i;

  // length as the block uses it: zero acts as one, oversize saturates
  function automatic logic [CFG_W-1:0] eff_length(logic [CFG_W-1:0] len);
    if (len == '0) return CFG_W'(1);
    if (len > CFG_W'(DEF_MAX_LENGTH)) return CFG_W'(DEF_MAX_LENGTH);
    return len;
  endfunction

  // next result of the sampler, updating the bitmap and count
  function automatic sampler_res_t predict_sample(sampler_item_t item);
    logic [CFG_W-1:0]  n;
    logic [CFG_W-1:0]  target;
    logic [WORD_W-1:0] residue;
    sampler_res_t      res;
    n = eff_length(len_reg);
    target = (weight_reg < n) ? weight_reg : n;
    res = '0;
    if (item.op == OP_START) begin
      chosen_map = '0;
      picked_count = '0;
    end else begin
      residue = item.word % WORD_W'(n);
      res.position = residue[POS_W-1:0];
      if (picked_count < target && !chosen_map[res.position]) begin
        chosen_map[res.position] = 1'b1;
        picked_count = picked_count + 1'b1;
        res.newly_chosen = 1'b1;
      end
    end
    res.chosen_count = picked_count;
    res.done_res = (picked_count >= target);
    return res;
  endfunction

  task automatic queue_item(logic op, logic [WORD_W-1:0] word);
    sampler_item_t item;
    item.op = op;
    item.word = word;
    pending_items_q.push_back(item);
    n_queued++;
  endtask

  // wait until every queued item is taken and every result has come
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_res_q.size() != 0) @(negedge clk_i);
  endtask

  // back-to-back writes of both registers, called at a falling edge while idle
  task automatic program_regs(logic [CFG_W-1:0] len, logic [CFG_W-1:0] wt);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_VECTOR_LENGTH;
    cfg_data_i <= len;
    @(negedge clk_i);
    cfg_idx_i  <= REG_TARGET_WEIGHT;
    cfg_data_i <= wt;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_pct = 0;
        recv_pct = 0;
      end
      IDLE_SENDER: begin
        send_pct = 51;
        recv_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_pct = 0;
        recv_pct = 51;
      end
      default: begin
        send_pct = 29;
        recv_pct = 29;
      end
    endcase
  endtask

  // one sample: a start, then words that hit fresh, repeated and random positions
  task automatic queue_sample(logic [CFG_W-1:0] len, logic [CFG_W-1:0] wt, bit skip_start);
    logic [CFG_W-1:0]  n;
    logic [CFG_W-1:0]  target;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] prev_word;
    int unsigned       n_words;
    n = eff_length(len);
    target = (wt < n) ? wt : n;
    prev_word = {$urandom, $urandom};
    n_words = (target <= 16) ? 4 * target + $urandom_range(1, 4) : $urandom_range(8, 40);
    if (!skip_start) queue_item(OP_START, {$urandom, $urandom});
    for (int i = 0; i < n_words; i++) begin
      // rare restart in the middle of a sample
      if ($urandom_range(0, 39) == 0) begin
        queue_item(OP_START, {$urandom, $urandom});
      end else begin
        case ($urandom_range(0, 6))
          0, 1, 2: word = {$urandom, $urandom};
          3, 4, 5: word = WORD_W'($urandom) * WORD_W'(n) + WORD_W'($urandom_range(0, n - 1));
          default: word = prev_word;
        endcase
        queue_item(OP_WORD, word);
        prev_word = word;
      end
    end
  endtask

  // input driver: holds an item until taken, idles at random
  always @(negedge clk_i) begin
    sampler_item_t cur;
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (pending_items_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
        cur = pending_items_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.op          <= cur.op;
        in_if.random_word <= cur.word;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver stalls at random
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_pct);
  end

  // monitor: register writes, accepted items, result checks and watchdog
  always @(posedge clk_i) begin : monitor
    sampler_item_t item;
    sampler_res_t  got;
    sampler_res_t  want;
    logic          out_fire;
    in_fire = rst_ni && in_if.valid && in_if.ready;
    out_fire = rst_ni && out_if.valid && out_if.ready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_VECTOR_LENGTH) len_reg = cfg_data_i;
        else weight_reg = cfg_data_i;
      end
      if (in_fire) begin
        item.op = in_if.op;
        item.word = in_if.random_word;
        expected_res_q.push_back(predict_sample(item));
        n_accepted++;
      end
      if (out_fire) begin
        got.position = out_if.position;
        got.newly_chosen = out_if.newly_chosen;
        got.chosen_count = out_if.chosen_count;
        got.done_res = out_if.done_res;
        n_results++;
        if (expected_res_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: result with none expected: pos %0d new %0b count %0d done %0b",
                     $time, got.position, got.newly_chosen, got.chosen_count, got.done_res);
        end else begin
          want = expected_res_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display("%0t: mismatch: expected pos %0d new %0b count %0d done %0b, %s",
                       $time, want.position, want.newly_chosen, want.chosen_count,
                       want.done_res,
                       $sformatf("got pos %0d new %0b count %0d done %0b", got.position,
                                 got.newly_chosen, got.chosen_count, got.done_res));
          end
          if (want.newly_chosen) n_fresh++;
          if (want.done_res) n_done++;
        end
      end
      // watchdog on cycles without any handshake
      if (in_fire || out_fire) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results outstanding", STALL_LIMIT,
                 expected_res_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] wt;
    int unsigned      phase_base;
    bit               first;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_VECTOR_LENGTH;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_START;
    in_if.random_word = '0;
    out_if.ready = 1'b0;
    in_fire = 1'b0;
    chosen_map = '0;
    picked_count = '0;
    len_reg = RST_VECTOR_LENGTH;
    weight_reg = RST_TARGET_WEIGHT;
    n_queued = 0;
    n_accepted = 0;
    n_results = 0;
    n_fresh = 0;
    n_done = 0;
    n_settings = 0;
    n_fail = 0;
    stall_cycles = 0;
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset registers: a word before any start, wrap-around and repeated positions
    queue_item(OP_WORD, '0);
    queue_item(OP_START, '0);
    queue_item(OP_WORD, '1);
    queue_item(OP_WORD, '0);
    queue_item(OP_WORD, 64'd4096);
    queue_item(OP_WORD, 64'h8000_0000_0000_0000);
    queue_item(OP_WORD, 64'h0123_4567_89ab_cdef);
    wait_drained();

    // length and weight shrunk mid-sample, then a sample finished and overrun
    program_regs(13'd3, 13'd2);
    queue_item(OP_WORD, 64'd1);
    queue_item(OP_START, '1);
    queue_item(OP_WORD, 64'd5);
    queue_item(OP_WORD, 64'd8);
    queue_item(OP_WORD, 64'd4);
    queue_item(OP_WORD, 64'd0);
    wait_drained();

    // zero length acts as one, weight far above the length
    program_regs(13'd0, 13'd8191);
    queue_item(OP_START, '0);
    queue_item(OP_WORD, '1);
    queue_item(OP_WORD, 64'd7);
    wait_drained();

    // oversized length saturates, zero weight is done at once
    program_regs(13'd8191, 13'd0);
    queue_item(OP_START, '0);
    queue_item(OP_WORD, '1);
    wait_drained();

    // largest length and weight
    program_regs(13'd4096, 13'd4096);
    queue_item(OP_START, '0);
    queue_item(OP_WORD, 64'h0000_0000_0000_1000);
    queue_item(OP_WORD, 64'hffff_ffff_ffff_f001);
    wait_drained();

    // random phases: each drains fully before the next register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_idle(idle_mode_e'(p % 4));
      case ($urandom_range(0, 9))
        0:       len = 13'd1;
        1:       len = 13'd0;
        2:       len = 13'd8191;
        3:       len = 13'd4096;
        4:       len = CFG_W'($urandom_range(17, 4095));
        default: len = CFG_W'($urandom_range(2, 16));
      endcase
      if (p == 0) len = 13'd1;
      case ($urandom_range(0, 9))
        0:       wt = '0;
        1:       wt = 13'd8191;
        2:       wt = 13'd4096;
        3:       wt = eff_length(len);
        default: wt = CFG_W'($urandom_range(1, 12));
      endcase
      program_regs(len, wt);
      phase_base = n_queued;
      first = 1'b1;
      while (n_queued - phase_base < PHASE_ITEMS) begin
        // sometimes carry on the sample left from the previous setting
        queue_sample(len, wt, first && ($urandom_range(0, 3) == 0));
        first = 1'b0;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_res_q.size() != 0) n_fail += expected_res_q.size();
    $display("run covered %0d items under %0d register settings and four idle patterns",
             n_accepted, n_settings);
    $display("%0d results checked, %0d positions newly chosen, %0d results with done set",
             n_results, n_fresh, n_done);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/fwis_pkg.sv
sv/fwis_if.sv
sv/fwis_div.sv
sv/fwis_map.sv
sv/fixed_weight_index_sampler_unit.sv
sv/fwis_checker.sv
verif/tb.sv
